/* rtl/core/trajectory_staleness_steer_gate_unit_assert.svh */
// assertion macros for the steering gate
// plain implication and invariant forms, clocked on the rising edge, held off during reset
`ifndef TRAJECTORY_STALENESS_STEER_GATE_UNIT_ASSERT_SVH
`define TRAJECTORY_STALENESS_STEER_GATE_UNIT_ASSERT_SVH

// antecedent in a cycle implies consequent in the same cycle
`define TSSG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds at every edge out of reset
`define TSSG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

/* rtl/core/tssg_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and stage types for the steering gate
// no dependencies
package tssg_pkg;

   localparam int HORIZON_LEN = 20;
   localparam int BANK_DEPTH  = 2 * HORIZON_LEN;
   localparam int ADDR_W      = $clog2(BANK_DEPTH);
   localparam int STEP_W      = $clog2(HORIZON_LEN + 1);
   localparam int MAG_W       = 16 + STEP_W;
   // reciprocal of the horizon length, exact floor for any MAG_W-bit dividend
   localparam int QUO_SHIFT   = MAG_W + $clog2(HORIZON_LEN);
   localparam int RECIP_W     = MAG_W + 1;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam longint RECIP   =
      ((longint'(1) << QUO_SHIFT) + longint'(HORIZON_LEN) - 1) / longint'(HORIZON_LEN);
   localparam int CSR_ADDR_W  = 4;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_COMMIT = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_NO_PLAN   = 2'd0,
      MODE_FRESH     = 2'd1,
      MODE_REPLAY    = 2'd2,
      MODE_SAFE_STOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_STALE_LIMIT     = 2'd0,
      REG_STEER_STEP      = 2'd1,
      REG_COMFORT_DECEL   = 2'd2,
      REG_EMERGENCY_DECEL = 2'd3
   } csr_reg_type;

   // scaled horizon magnitude handed from the plan stage to the slew stage
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } scale_type;

endpackage

/* rtl/core/trajectory_staleness_steer_gate_unit.sv */
`timescale 1ns / 1ps
// steering gate top level: request register, plan, middle and slew stages, result register
// depends on tssg_pkg, tssg_ram, tssg_slew and the assertion macro header
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+------------------------------
//   req     | req_valid / req_stall / req_*  | in        | load, commit or tick request
//   rsp     | rsp_valid / rsp_stall / rsp_*  | out       | one result per tick
//   csr     | psel penable pwrite paddr ...  | in/out    | four limit registers
//
// one request per cycle unless stalled; a tick's result passes the middle and result registers
// the horizon ram read is issued at acceptance from the state left by the request ahead of it
// a stalled result freezes the plan and slew stages; the request register still fills once
// sync reset clears control state, presets limits; horizon entries are undefined until loaded
`include "trajectory_staleness_steer_gate_unit_assert.svh"

module trajectory_staleness_steer_gate_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic [4:0]                      req_entry_index,
   input  logic signed [15:0]              req_steer_value,
   input  logic signed [15:0]              req_plan_accel,
   input  logic [31:0]                     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_steer_cmd,
   output logic signed [15:0]              rsp_accel_cmd,
   output logic [1:0]                      rsp_gate_mode,
   output logic [4:0]                      rsp_replay_step,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tssg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import tssg_pkg::*;

   // configuration
   logic [15:0] stale_limit_ff;
   logic [11:0] steer_step_ff;
   logic [14:0] comfort_decel_ff;
   logic [14:0] emergency_decel_ff;
   logic        csr_write;
   csr_reg_type csr_index;

   // request register
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [1:0]         in_op_ff;
   logic [4:0]         in_index_ff;
   logic signed [15:0] in_steer_ff;
   logic signed [15:0] in_accel_ff;
   logic [31:0]        in_time_ff;
   logic               req_accept;
   logic               advance;
   logic               in_take;

   // plan state
   logic               bank_ff;
   logic               bank_in;
   logic signed [15:0] held_accel_ff;
   logic signed [15:0] held_accel_in;
   logic               plan_present_ff;
   logic               plan_present_in;
   logic [31:0]        receive_time_ff;
   logic [31:0]        receive_time_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;

   // plan stage
   logic [31:0]        age;
   logic               fresh;
   logic               is_load;
   logic               is_tick;
   logic [STEP_W-1:0]  scale_k;
   logic signed [15:0] entry_sel;
   logic [15:0]        entry_abs;
   logic signed [15:0] tick_accel;
   mode_type           tick_mode;

   // horizon ram
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [15:0]       rd_entry_one;
   logic [15:0]       rd_entry_step;

   // stage between plan and slew
   scale_type          mid_scale_ff;
   scale_type          mid_scale_in;
   logic signed [15:0] mid_accel_ff;
   mode_type           mid_mode_ff;
   logic [STEP_W-1:0]  mid_step_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_accel_ff;
   mode_type           rsp_mode_ff;
   logic [STEP_W-1:0]  rsp_step_ff;
   logic signed [15:0] slew_steer;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff     <= 16'd200;
         steer_step_ff      <= 12'd123;
         comfort_decel_ff   <= 15'd384;
         emergency_decel_ff <= 15'd1024;
      end else if (csr_write) begin
         case (csr_index)
            REG_STALE_LIMIT:     stale_limit_ff     <= pwdata[15:0];
            REG_STEER_STEP:      steer_step_ff      <= pwdata[11:0];
            REG_COMFORT_DECEL:   comfort_decel_ff   <= pwdata[14:0];
            REG_EMERGENCY_DECEL: emergency_decel_ff <= pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_STALE_LIMIT:     prdata = 32'(stale_limit_ff);
         REG_STEER_STEP:      prdata = 32'(steer_step_ff);
         REG_COMFORT_DECEL:   prdata = 32'(comfort_decel_ff);
         REG_EMERGENCY_DECEL: prdata = 32'(emergency_decel_ff);
         default:             prdata = '0;
      endcase
   end

   // ---------------- request register ----------------
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign in_take     = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= req_op;
         in_index_ff <= req_entry_index;
         in_steer_ff <= req_steer_value;
         in_accel_ff <= req_plan_accel;
         in_time_ff  <= req_time_ms;
      end
   end

   // ---------------- plan stage ----------------
   assign is_load = in_take && (in_op_ff == OP_LOAD);
   assign is_tick = in_take && (in_op_ff == OP_TICK);
   assign age     = in_time_ff - receive_time_ff;
   assign fresh   = age <= {16'b0, stale_limit_ff};

   always_comb begin
      bank_in         = bank_ff;
      held_accel_in   = held_accel_ff;
      plan_present_in = plan_present_ff;
      receive_time_in = receive_time_ff;
      step_in         = step_ff;
      scale_k         = '0;
      entry_sel       = $signed(rd_entry_step);
      tick_accel      = -$signed({1'b0, comfort_decel_ff});
      tick_mode       = MODE_NO_PLAN;

      if (in_take && (in_op_ff == OP_COMMIT)) begin
         bank_in         = !bank_ff;
         held_accel_in   = in_accel_ff;
         plan_present_in = 1'b1;
         receive_time_in = in_time_ff;
         step_in         = STEP_W'(1);
      end

      if (plan_present_ff && fresh) begin
         // full scale so that the divide returns entry one unchanged
         scale_k    = STEP_W'(HORIZON_LEN);
         entry_sel  = $signed(rd_entry_one);
         tick_accel = held_accel_ff;
         tick_mode  = MODE_FRESH;
      end else if (plan_present_ff && (step_ff < STEP_W'(HORIZON_LEN))) begin
         scale_k    = STEP_W'(HORIZON_LEN) - step_ff;
         tick_mode  = MODE_REPLAY;
      end else if (plan_present_ff) begin
         tick_accel = -$signed({1'b0, emergency_decel_ff});
         tick_mode  = MODE_SAFE_STOP;
      end

      if (is_tick) begin
         case (tick_mode)
            MODE_FRESH:  step_in = STEP_W'(2);
            MODE_REPLAY: step_in = step_ff + STEP_W'(1);
            default:     step_in = step_ff;
         endcase
      end
   end

   assign entry_abs    = entry_sel[15] ? 16'(-entry_sel) : 16'(entry_sel);
   assign mid_scale_in = '{valid: is_tick,
                           neg:   entry_sel[15],
                           mag:   MAG_W'(entry_abs) * MAG_W'(scale_k)};

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff         <= 1'b0;
         held_accel_ff   <= '0;
         plan_present_ff <= 1'b0;
         receive_time_ff <= '0;
         step_ff         <= STEP_W'(1);
      end else begin
         bank_ff         <= bank_in;
         held_accel_ff   <= held_accel_in;
         plan_present_ff <= plan_present_in;
         receive_time_ff <= receive_time_in;
         step_ff         <= step_in;
      end
   end

   // ---------------- horizon ram ----------------
   // loads go to the shadow bank, reads come from the bank in use after the request ahead
   assign wr_en     = is_load && ({1'b0, in_index_ff} < 6'(HORIZON_LEN));
   assign wr_addr   = (bank_ff ? ADDR_W'(0) : ADDR_W'(HORIZON_LEN)) + ADDR_W'(in_index_ff);
   assign rd_addr_a = (bank_in ? ADDR_W'(HORIZON_LEN) : ADDR_W'(0)) + ADDR_W'(1);
   assign rd_addr_b = (bank_in ? ADDR_W'(HORIZON_LEN) : ADDR_W'(0))
                    + ((step_in < STEP_W'(HORIZON_LEN)) ? ADDR_W'(step_in) : ADDR_W'(0));

   tssg_ram #(
      .WIDTH (16),
      .DEPTH (BANK_DEPTH)
   ) u_horizon (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (in_steer_ff),
      .rd_en     (req_accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_entry_one),
      .rd_data_b (rd_entry_step)
   );

   // ---------------- middle stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_scale_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_scale_ff.valid <= mid_scale_in.valid;
      end
      if (advance && is_tick) begin
         mid_scale_ff.neg <= mid_scale_in.neg;
         mid_scale_ff.mag <= mid_scale_in.mag;
         mid_accel_ff     <= tick_accel;
         mid_mode_ff      <= tick_mode;
         mid_step_ff      <= step_in;
      end
   end

   // ---------------- slew stage ----------------
   tssg_slew u_slew (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .scale      (mid_scale_ff),
      .step_limit (steer_step_ff),
      .steer_cmd  (slew_steer)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mid_scale_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && mid_scale_ff.valid) begin
         rsp_accel_ff <= mid_accel_ff;
         rsp_mode_ff  <= mid_mode_ff;
         rsp_step_ff  <= mid_step_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_steer_cmd   = slew_steer;
   assign rsp_accel_cmd   = rsp_accel_ff;
   assign rsp_gate_mode   = rsp_mode_ff;
   assign rsp_replay_step = 5'(rsp_step_ff);

   // ---------------- assertions ----------------
   `TSSG_ASSERT_IMPLIES(a_fresh_step, clock, reset, rsp_valid_ff && (rsp_mode_ff == MODE_FRESH), rsp_step_ff == STEP_W'(2), "fresh result without step two")
   `TSSG_ASSERT_IMPLIES(a_stop_step, clock, reset, rsp_valid_ff && (rsp_mode_ff == MODE_SAFE_STOP), rsp_step_ff == STEP_W'(HORIZON_LEN), "safe stop before horizon end")
   `TSSG_ASSERT_IMPLIES(a_plan_mode, clock, reset, rsp_valid_ff && (rsp_mode_ff != MODE_NO_PLAN), plan_present_ff, "plan mode without a committed plan")
   `TSSG_ASSERT_ALWAYS(a_step_range, clock, reset, (step_ff >= STEP_W'(1)) && (step_ff <= STEP_W'(HORIZON_LEN)), "step outside horizon")
   `TSSG_ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, rsp_valid_ff && rsp_stall, "request stalled with result side free")

endmodule

/* rtl/core/tssg_ram.sv */
`timescale 1ns / 1ps
// generic ram: one write port, two read ports with registered read data
// no package dependencies
module tssg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

/* rtl/core/tssg_slew.sv */
`timescale 1ns / 1ps
// slew stage: divides the scaled entry by the horizon length and rate limits the steering
// depends on tssg_pkg
module tssg_slew (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tssg_pkg::scale_type scale,
   input  logic [11:0]         step_limit,
   output logic signed [15:0]  steer_cmd
);
   import tssg_pkg::*;

   logic [PROD_W-1:0]  prod;
   logic [15:0]        quot;
   logic signed [16:0] target;
   logic signed [17:0] diff;
   logic signed [17:0] lim;
   logic signed [17:0] clamped;
   logic signed [17:0] sum;
   logic signed [15:0] steer_ff;
   logic signed [15:0] steer_in;

   // divide by constant through the reciprocal, exact for the full magnitude range
   assign prod = PROD_W'(scale.mag) * PROD_W'(RECIP);
   assign quot = prod[QUO_SHIFT +: 16];

   always_comb begin
      target  = scale.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      diff    = 18'(target) - 18'(steer_ff);
      lim     = $signed({6'b0, step_limit});
      if (diff > lim) begin
         clamped = lim;
      end else if (diff < -lim) begin
         clamped = -lim;
      end else begin
         clamped = diff;
      end
      sum = 18'(steer_ff) + clamped;
      if (sum > 18'sd32767) begin
         steer_in = 16'sh7fff;
      end else if (sum < -18'sd32768) begin
         steer_in = 16'sh8000;
      end else begin
         steer_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_ff <= '0;
      end else if (advance && scale.valid) begin
         steer_ff <= steer_in;
      end
   end

   assign steer_cmd = steer_ff;

endmodule
